### rtl/nested_call_interval_profiler_top_macros.svh
// assertion macros for the call profiler
`ifndef NESTED_CALL_INTERVAL_PROFILER_TOP_MACROS_SVH
`define NESTED_CALL_INTERVAL_PROFILER_TOP_MACROS_SVH
`define NCIP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define NCIP_ASSERT_R(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

### rtl/ncip_pkg.sv
// shared types and constants of the call profiler
package ncip_pkg;
  localparam int unsigned SLOT_W = 6;
  localparam int unsigned TS_W = 32;
  localparam int unsigned MS_W = 23;
  localparam logic [9:0] US_PER_MS = 10'd1000;
  localparam logic [7:0] DEPTH_MAX = 8'd255;

  typedef enum logic [1:0] {
    ACT_ENTER = 2'd0,
    ACT_EXIT = 2'd1,
    ACT_REPORT = 2'd2,
    ACT_NONE = 2'd3
  } act_t;

  typedef struct packed {
    act_t act;
    logic [SLOT_W-1:0] slot;
    logic [TS_W-1:0] ts;
  } cmd_t;

  // divide by 1000: reciprocal 274877907/2^38 exact for 32-bit operands
  function automatic logic [MS_W-1:0] us_to_ms(input logic [TS_W-1:0] us);
    logic [63:0] p;
    begin
      p = {32'd0, us} * 64'd274877907;
      return p[38 +: MS_W];
    end
  endfunction
endpackage

### rtl/nested_call_interval_profiler_top.sv
// call profiler top level: 2-entry command queue between front and back end
// enter/exit: state updated in S_EV after the back end takes the command; no new
// command is taken until S_IDLE. report: gather pass over all slots, then a sort
// pass per slot line, then rebase; the back end serializes all per-slot storage
// synchronous reset clears live mask, queue, and per-slot valid bits (all zero)
module nested_call_interval_profiler_top
  import ncip_pkg::*;
#(
  parameter int unsigned SLOTS = 48
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [47:0] cfg_wdata,
  input  logic in_valid,
  output logic in_ready,
  input  logic [1:0] action,
  input  logic [5:0] slot,
  input  logic [31:0] timestamp_us,
  output logic out_valid,
  input  logic out_ready,
  output logic [5:0] slot_index,
  output logic [22:0] interval_ms,
  output logic [31:0] interval_calls,
  output logic [22:0] worst_ms,
  output logic is_summary,
  output logic [5:0] never_called_count,
  output logic [31:0] interval_total_calls,
  output logic last
);
  logic [SLOTS-1:0] live;
  logic q_valid, q_ready;
  cmd_t q_cmd;

  always_ff @(posedge clk) begin
    if (rst) live <= '0;
    else if (cfg_we) live <= cfg_wdata[SLOTS-1:0];
  end

  ncip_front #(.SLOTS(SLOTS)) u_front (
    .clk, .rst, .valid(in_valid), .ready(in_ready), .action, .slot, .timestamp_us,
    .live, .q_valid, .q_ready, .q_cmd
  );

  ncip_back #(.SLOTS(SLOTS)) u_back (
    .clk, .rst, .live, .q_valid, .q_ready, .q_cmd,
    .out_valid, .out_ready,
    .out_slot(slot_index), .out_ims(interval_ms), .out_icalls(interval_calls),
    .out_wms(worst_ms), .out_summ(is_summary), .out_never(never_called_count),
    .out_total(interval_total_calls), .out_last(last)
  );
endmodule

### rtl/ncip_front.sv
// front end: accepts events, drops the ones that do nothing, queues commands
module ncip_front
  import ncip_pkg::*;
#(
  parameter int unsigned SLOTS = 48
) (
  input  logic clk,
  input  logic rst,
  input  logic valid,
  output logic ready,
  input  logic [1:0] action,
  input  logic [SLOT_W-1:0] slot,
  input  logic [TS_W-1:0] timestamp_us,
  input  logic [SLOTS-1:0] live,
  output logic q_valid,
  input  logic q_ready,
  output cmd_t q_cmd
);
  localparam int unsigned QD = 2;
  cmd_t q [QD];
  logic rd_ptr, wr_ptr;
  logic [1:0] cnt;
  logic keep, push, pop;
  logic slot_live;

  always_comb begin
    slot_live = 1'b0;
    for (int i = 0; i < SLOTS; i++)
      if (slot == SLOT_W'(i)) slot_live = live[i];
  end

  assign keep = (action == ACT_REPORT) ? (|live)
              : ((action == ACT_ENTER || action == ACT_EXIT) && slot_live);
  assign ready = (cnt != 2'd2);
  assign push = valid && ready && keep;
  assign pop = q_valid && q_ready;
  assign q_valid = (cnt != 2'd0);
  assign q_cmd = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) q[wr_ptr] <= '{act: act_t'(action), slot: slot, ts: timestamp_us};
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

### rtl/ncip_back.sv
// back end: per-slot read-modify-write and the report sort
module ncip_back
  import ncip_pkg::*;
#(
  parameter int unsigned SLOTS = 48
) (
  input  logic clk,
  input  logic rst,
  input  logic [SLOTS-1:0] live,
  input  logic q_valid,
  output logic q_ready,
  input  cmd_t q_cmd,
  output logic out_valid,
  input  logic out_ready,
  output logic [SLOT_W-1:0] out_slot,
  output logic [MS_W-1:0] out_ims,
  output logic [31:0] out_icalls,
  output logic [MS_W-1:0] out_wms,
  output logic out_summ,
  output logic [SLOT_W-1:0] out_never,
  output logic [31:0] out_total,
  output logic out_last
);
  localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CW = $clog2(SLOTS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_EV, S_RP_RD, S_RP_DIV, S_RP_NEXT, S_SC_RD, S_SC_CMP,
    S_EMIT_RD, S_EMIT_DIV, S_EMIT, S_SUMM, S_RB_RD, S_REBASE
  } st_t;
  st_t st;

  // per-slot storage (valid bits clear it at reset)
  logic [7:0] depth [SLOTS];
  logic [SLOTS-1:0] vld;
  logic [31:0] m_entry [SLOTS];
  logic [31:0] m_calls [SLOTS];
  logic [31:0] m_total [SLOTS];
  logic [31:0] m_worst [SLOTS];
  logic [31:0] m_bcalls [SLOTS];
  logic [31:0] m_btime [SLOTS];
  // per-report scratch
  logic [MS_W-1:0] r_ms [SLOTS];
  logic [31:0] r_calls [SLOTS];
  logic [SLOTS-1:0] pend;

  logic [IW-1:0] idx, best;
  logic best_ok;
  logic [MS_W-1:0] best_ms;
  cmd_t cmd;
  logic [31:0] rd_entry, rd_calls, rd_total, rd_worst, rd_bc, rd_bt;
  logic rd_vld, rd_pend;
  logic [7:0] rd_depth;
  logic [MS_W-1:0] rd_ms;
  logic [31:0] rd_rcalls;
  logic [31:0] spent, d_time, sum;
  logic [CW-1:0] never;
  logic [32:0] sum_w;
  logic [IW-1:0] sidx;

  assign sidx = cmd.slot[IW-1:0];
  assign q_ready = (st == S_IDLE);
  assign spent = cmd.ts - rd_entry;
  assign sum_w = {1'b0, sum} + {1'b0, rd_calls - rd_bc};

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
      vld <= '0;
      out_valid <= 1'b0;
      pend <= '0;
    end else begin
      unique case (st)
        S_IDLE: begin
          if (q_valid) begin
            cmd <= q_cmd;
            if (q_cmd.act == ACT_REPORT) begin
              idx <= '0;
              sum <= '0;
              never <= '0;
              st <= S_RP_RD;
            end else begin
              st <= S_EV;
            end
          end
        end
        S_EV: begin
          // read side registered in the previous cycle
          if (cmd.act == ACT_ENTER) begin
            if (rd_depth == 8'd0) m_entry[sidx] <= cmd.ts;
            if (!rd_vld) begin
              vld[sidx] <= 1'b1;
              depth[sidx] <= 8'd1;
              m_calls[sidx] <= '0; m_total[sidx] <= '0; m_worst[sidx] <= '0;
              m_bcalls[sidx] <= '0; m_btime[sidx] <= '0;
            end else if (rd_depth != DEPTH_MAX) begin
              depth[sidx] <= rd_depth + 8'd1;
            end
          end else if (rd_depth != 8'd0) begin
            depth[sidx] <= rd_depth - 8'd1;
            if (rd_depth == 8'd1) begin
              m_calls[sidx] <= rd_calls + 32'd1;
              m_total[sidx] <= rd_total + spent;
              if (spent > rd_worst) m_worst[sidx] <= spent;
            end
          end
          st <= S_IDLE;
        end
        S_RP_RD: st <= S_RP_DIV;
        S_RP_DIV: begin
          r_ms[idx] <= us_to_ms(d_time);
          r_calls[idx] <= rd_calls - rd_bc;
          pend[idx] <= live[idx] && (rd_calls != rd_bc);
          if (live[idx]) begin
            sum <= sum_w[32] ? 32'hFFFF_FFFF : sum_w[31:0];
            if (rd_calls == 32'd0) never <= never + CW'(1);
          end
          st <= S_RP_NEXT;
        end
        S_RP_NEXT: begin
          if (idx == IW'(SLOTS - 1)) begin
            idx <= '0;
            best_ok <= 1'b0;
            st <= S_SC_RD;
          end else begin
            idx <= idx + IW'(1);
            st <= S_RP_RD;
          end
        end
        S_SC_RD: st <= S_SC_CMP;
        S_SC_CMP: begin
          if (rd_pend && (!best_ok || rd_ms > best_ms)) begin
            best <= idx;
            best_ms <= rd_ms;
            best_ok <= 1'b1;
          end
          if (idx == IW'(SLOTS - 1)) begin
            st <= (rd_pend || best_ok) ? S_EMIT_RD : S_SUMM;
            if (rd_pend && (!best_ok || rd_ms > best_ms)) idx <= idx;
            else idx <= best;
          end else begin
            idx <= idx + IW'(1);
            st <= S_SC_RD;
          end
        end
        S_EMIT_RD: st <= S_EMIT_DIV;
        S_EMIT_DIV: begin
          out_slot <= SLOT_W'(idx);
          out_ims <= rd_ms;
          out_icalls <= rd_rcalls;
          out_wms <= us_to_ms(rd_worst);
          out_summ <= 1'b0;
          out_never <= '0;
          out_total <= '0;
          out_last <= 1'b0;
          out_valid <= 1'b1;
          pend[idx] <= 1'b0;
          st <= S_EMIT;
        end
        S_EMIT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            idx <= '0;
            best_ok <= 1'b0;
            st <= S_SC_RD;
          end
        end
        S_SUMM: begin
          if (!out_valid) begin
            out_slot <= '0; out_ims <= '0; out_icalls <= '0; out_wms <= '0;
            out_summ <= 1'b1;
            out_never <= SLOT_W'(never);
            out_total <= sum;
            out_last <= 1'b1;
            out_valid <= 1'b1;
          end else if (out_ready) begin
            out_valid <= 1'b0;
            idx <= '0;
            st <= S_RB_RD;
          end
        end
        S_RB_RD: st <= S_REBASE;
        S_REBASE: begin
          m_bcalls[idx] <= rd_calls;
          m_btime[idx] <= rd_total;
          if (idx == IW'(SLOTS - 1)) begin
            st <= S_IDLE;
          end else begin
            idx <= idx + IW'(1);
            st <= S_RB_RD;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  // registered reads, invalid entries read as zero
  logic [IW-1:0] ra;
  always_comb ra = (st == S_IDLE) ? q_cmd.slot[IW-1:0] : idx;
  always_ff @(posedge clk) begin
    rd_vld <= vld[ra];
    rd_depth <= vld[ra] ? depth[ra] : '0;
    rd_entry <= vld[ra] ? m_entry[ra] : '0;
    rd_calls <= vld[ra] ? m_calls[ra] : '0;
    rd_total <= vld[ra] ? m_total[ra] : '0;
    rd_worst <= vld[ra] ? m_worst[ra] : '0;
    rd_bc <= vld[ra] ? m_bcalls[ra] : '0;
    rd_bt <= vld[ra] ? m_btime[ra] : '0;
    rd_ms <= r_ms[idx];
    rd_rcalls <= r_calls[idx];
    rd_pend <= pend[idx];
  end
  assign d_time = rd_total - rd_bt;

`include "nested_call_interval_profiler_top_macros.svh"
  `NCIP_ASSERT(a_busy_no_take, (st != S_IDLE) |-> !q_ready, "took word while busy")
  `NCIP_ASSERT(a_out_hold, (out_valid && !out_ready) |=> out_valid, "result dropped")
  `NCIP_ASSERT(a_last_summ, out_valid |-> (out_last == out_summ), "last without summary")
  `NCIP_ASSERT_R(a_rst_idle, rst |=> (st == S_IDLE && !out_valid), "reset not idle")
endmodule
